>>> rtl/core/krrp_pkg.sv
// Shared types, constants and tracker functions for the key repeat / record / playback block.
`timescale 1ns / 1ps
`default_nettype none
package krrp_pkg;

	localparam int KEY_W   = 10;
	localparam int WORD_W  = 16;
	localparam int POS_W   = 11;
	localparam int TMR_W   = 6;
	localparam int CNT_W   = 4;
	localparam int PADDR_W = 4;

	localparam logic [CNT_W-1:0] REPEAT_LIMIT  = 4'd14;
	localparam logic [CNT_W-1:0] REPEAT_RELOAD = 4'd12;
	localparam logic [TMR_W:0]   RUN_MAX       = 7'd64;
	localparam logic [WORD_W-1:0] COUNT_UNIT   = 16'h0400;

	localparam logic [2:0] MODE_LIVE    = 3'd0;
	localparam logic [2:0] MODE_REC     = 3'd1;
	localparam logic [2:0] MODE_REPLACE = 3'd2;
	localparam logic [2:0] MODE_ALT     = 3'd3;
	localparam logic [2:0] MODE_OR      = 3'd4;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_FILTER = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_LOAD  = 2'd2,
		ACT_READ  = 2'd3
	} action_e;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_WIPE
	} state_e;

	typedef struct packed {
		action_e            action;
		logic [KEY_W-1:0]   raw_keys;
		logic               pause;
		logic [KEY_W-1:0]   entry_index;
		logic [WORD_W-1:0]  entry_word;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        rec_mode;
		logic [KEY_W-1:0]  key_filter;
		logic [POS_W-1:0]  entry_limit;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] prev;
		logic [KEY_W-1:0] rref;
		logic [CNT_W-1:0] count;
	} trk_t;

	typedef struct packed {
		logic [KEY_W-1:0] held;
		logic [KEY_W-1:0] pressed;
		logic [KEY_W-1:0] released;
		logic [KEY_W-1:0] rpt;
	} ev_t;

	typedef struct packed {
		ev_t               main;
		ev_t               alt;
		logic [POS_W-1:0]  next_position;
		logic              reached_end;
		logic [WORD_W-1:0] read_word;
	} res_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	function automatic trk_t trk_next(trk_t t, logic [KEY_W-1:0] keys);
		logic [KEY_W-1:0] diff;
		logic [CNT_W-1:0] c;
		trk_t n;
		diff = keys ^ t.prev;
		c = t.count + 4'd1;
		n = t;
		n.prev = keys;
		if ((keys & diff) != '0) begin
			n.count = '0;
		end else begin
			n.rref = keys;
			if (t.rref == keys) begin
				n.count = (c > REPEAT_LIMIT) ? REPEAT_RELOAD : c;
			end else begin
				n.count = '0;
			end
		end
		return n;
	endfunction

	function automatic ev_t trk_events(trk_t t, logic [KEY_W-1:0] keys);
		logic [KEY_W-1:0] diff;
		logic [CNT_W-1:0] c;
		ev_t e;
		diff = keys ^ t.prev;
		c = t.count + 4'd1;
		e.held = keys;
		e.pressed = keys & diff;
		e.released = t.prev & diff;
		if (e.pressed != '0) begin
			e.rpt = e.pressed;
		end else if (t.rref == keys && c > REPEAT_LIMIT) begin
			e.rpt = keys;
		end else begin
			e.rpt = '0;
		end
		return e;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/krrp_ifs.sv
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface krrp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [9:0]  raw_keys;
	logic        pause;
	logic [9:0]  entry_index;
	logic [15:0] entry_word;

	modport source (output valid, action, raw_keys, pause, entry_index, entry_word,
		input ready);
	modport sink (input valid, action, raw_keys, pause, entry_index, entry_word,
		output ready);
endinterface

interface krrp_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  held_keys;
	logic [9:0]  pressed_keys;
	logic [9:0]  released_keys;
	logic [9:0]  repeat_keys;
	logic [9:0]  alt_held_keys;
	logic [9:0]  alt_pressed_keys;
	logic [9:0]  alt_released_keys;
	logic [9:0]  alt_repeat_keys;
	logic [10:0] next_position;
	logic        reached_end;
	logic [15:0] read_word;

	modport source (output valid, held_keys, pressed_keys, released_keys, repeat_keys,
		alt_held_keys, alt_pressed_keys, alt_released_keys, alt_repeat_keys,
		next_position, reached_end, read_word, input ready);
	modport sink (input valid, held_keys, pressed_keys, released_keys, repeat_keys,
		alt_held_keys, alt_pressed_keys, alt_released_keys, alt_repeat_keys,
		next_position, reached_end, read_word, output ready);
endinterface
`default_nettype wire

>>> rtl/core/key_repeat_record_playback.sv
// Top level: APB register file, front queue and back end of the key repeat / record block.
//
//  channel  | dir | handshake     | word
//  in_ch    | in  | valid / ready | action, raw_keys, pause, entry_index, entry_word
//  out_ch   | out | valid / ready | tracker masks, next_position, reached_end, read_word
//  apb      | in  | psel/penable  | rec_mode @0x0, key_filter @0x4, entry_limit @0x8
//
// Each word passes the back end as a store read, then an execute/write step that waits for a free output register.
// A recording start wipes store entries 0 to max(limit,1)-1, one store entry cleared per cycle.
// After reset every store entry is swept to zero; in_ch.ready stays low until the sweep ends.
// A two-deep queue and the output register let the two sides stall independently.
`timescale 1ns / 1ps
`default_nettype none
module key_repeat_record_playback #(
	parameter int STORE_DEPTH = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	krrp_in_if.sink                             in_ch,
	krrp_out_if.source                          out_ch,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [krrp_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import krrp_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	logic       cmd_valid, pop;
	res_t       res;
	back_stat_t stat;
	logic       wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rec_mode    <= MODE_LIVE;
			cfg_q.key_filter  <= '1;
			cfg_q.entry_limit <= '0;
		end else if (wr) begin
			case (paddr[3:2])
				REG_MODE:   cfg_q.rec_mode <= pwdata[2:0];
				REG_FILTER: cfg_q.key_filter <= pwdata[KEY_W-1:0];
				REG_LIMIT:  cfg_q.entry_limit <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:   prdata = {29'b0, cfg_q.rec_mode};
			REG_FILTER: prdata = {22'b0, cfg_q.key_filter};
			REG_LIMIT:  prdata = {21'b0, cfg_q.entry_limit};
			default:    prdata = '0;
		endcase
	end

	krrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.stat      (stat),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.pop       (pop)
	);

	krrp_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.pop       (pop),
		.res       (res),
		.res_valid (out_ch.valid),
		.res_ready (out_ch.ready),
		.stat      (stat)
	);

	assign out_ch.held_keys         = res.main.held;
	assign out_ch.pressed_keys      = res.main.pressed;
	assign out_ch.released_keys     = res.main.released;
	assign out_ch.repeat_keys       = res.main.rpt;
	assign out_ch.alt_held_keys     = res.alt.held;
	assign out_ch.alt_pressed_keys  = res.alt.pressed;
	assign out_ch.alt_released_keys = res.alt.released;
	assign out_ch.alt_repeat_keys   = res.alt.rpt;
	assign out_ch.next_position     = res.next_position;
	assign out_ch.reached_end       = res.reached_end;
	assign out_ch.read_word         = res.read_word;

endmodule
`default_nettype wire

>>> rtl/core/krrp_front.sv
// Front end: accepts input words, decodes the action and queues them (two deep).
`timescale 1ns / 1ps
`default_nettype none
module krrp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	krrp_in_if.sink                 in_ch,
	input  krrp_pkg::back_stat_t    stat,
	output krrp_pkg::cmd_t          cmd,
	output logic                    cmd_valid,
	input  wire logic               pop
);
	import krrp_pkg::*;

	cmd_t       q_mem [2];
	cmd_t       in_cmd;
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	always_comb begin
		in_cmd.action      = action_e'(in_ch.action);
		in_cmd.raw_keys    = in_ch.raw_keys;
		in_cmd.pause       = in_ch.pause;
		in_cmd.entry_index = in_ch.entry_index;
		in_cmd.entry_word  = in_ch.entry_word;
	end

	// nothing enters while the store is being swept after reset
	assign in_ch.ready = (cnt_q != 2'd2) && !stat.clearing;
	assign push = in_ch.valid && in_ch.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= in_cmd;
	end

endmodule
`default_nettype wire

>>> rtl/core/krrp_back.sv
// Back end: entry store, edge/repeat trackers, record and playback sequencing.
`timescale 1ns / 1ps
`default_nettype none
module krrp_back #(
	parameter int STORE_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  krrp_pkg::cfg_t          cfg,
	input  krrp_pkg::cmd_t          cmd,
	input  wire logic               cmd_valid,
	output logic                    pop,
	output krrp_pkg::res_t          res,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output krrp_pkg::back_stat_t    stat
);
	import krrp_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [16:0] DEPTH_W = 17'(STORE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

	logic [WORD_W-1:0] mem [STORE_DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     waddr, raddr;
	logic [WORD_W-1:0] wdata;

	state_e            state_q, state_d;
	cmd_t              cmd_q;
	trk_t              main_q, main_d, alt_q, alt_d;
	logic [POS_W-1:0]  pos_q, pos_d, pos1, lim;
	logic [TMR_W-1:0]  timer_q, timer_d;
	logic [AW-1:0]     sweep_q, sweep_d;
	res_t              res_q, res_d;
	logic              res_valid_q, res_valid_d;
	logic              out_free, idx_ok;
	logic [16:0]       pos_x, pos1_x, idx_x, sweep_x, idxq_x;
	logic [2:0]        mode;
	logic [KEY_W-1:0]  keys, played;
	logic [TMR_W:0]    t7;
	ev_t               ev_m, ev_a;
	logic [WORD_W-1:0] rd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rdata_q <= mem[raddr];
	end

	always_comb begin
		lim = ({6'b0, cfg.entry_limit} < DEPTH_W) ? cfg.entry_limit : DEPTH_W[POS_W-1:0];
		pos1 = pos_q + 11'd1;
		pos_x = {6'b0, pos_q};
		pos1_x = {6'b0, pos1};
		idx_x = {7'b0, cmd.entry_index};
		idxq_x = {7'b0, cmd_q.entry_index};
		sweep_x = 17'(sweep_q);
		idx_ok = idxq_x < DEPTH_W;
		mode = (cfg.rec_mode > MODE_OR) ? MODE_LIVE : cfg.rec_mode;
		out_free = !res_valid_q || res_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			main_q      <= '0;
			alt_q       <= '0;
			pos_q       <= '0;
			timer_q     <= '0;
			sweep_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			main_q      <= main_d;
			alt_q       <= alt_d;
			pos_q       <= pos_d;
			timer_q     <= timer_d;
			sweep_q     <= sweep_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= cmd;
		res_q <= res_d;
	end

	always_comb begin
		state_d = state_q;
		main_d = main_q;
		alt_d = alt_q;
		pos_d = pos_q;
		timer_d = timer_q;
		sweep_d = sweep_q;
		res_d = res_q;
		res_valid_d = res_valid_q && !res_ready;
		pop = 1'b0;
		mem_re = 1'b0;
		raddr = pos_x[AW-1:0];
		mem_we = 1'b0;
		waddr = pos_x[AW-1:0];
		wdata = '0;
		keys = '0;
		played = '0;
		t7 = '0;
		ev_m = '0;
		ev_a = '0;
		rd = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				waddr = sweep_q;
				sweep_d = sweep_q + 1'b1;
				if (sweep_q == LAST_ADDR) begin
					sweep_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					pop = 1'b1;
					mem_re = 1'b1;
					state_d = ST_EXEC;
					case (cmd.action)
						ACT_TICK: begin
							// playback stepping to the next entry needs that entry
							if (mode inside {MODE_REPLACE, MODE_ALT, MODE_OR} && !cmd.pause
									&& timer_q == '0)
								raddr = pos1_x[AW-1:0];
						end
						ACT_START: raddr = '0;
						default: raddr = idx_x[AW-1:0];
					endcase
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					res_valid_d = 1'b1;
					state_d = ST_IDLE;
					case (cmd_q.action)
						ACT_TICK: begin
							keys = cmd_q.raw_keys & cfg.key_filter;
							if (mode == MODE_REC) begin
								if (!cmd_q.pause && pos_q < lim) begin
									t7 = {1'b0, timer_q} + 7'd1;
									if (rdata_q[KEY_W-1:0] == keys && t7 < RUN_MAX) begin
										timer_d = t7[TMR_W-1:0];
										mem_we = 1'b1;
										wdata = rdata_q + COUNT_UNIT;
									end else begin
										timer_d = '0;
										pos_d = pos1;
										mem_we = pos1 < lim;
										waddr = pos1_x[AW-1:0];
										wdata = {6'b0, keys};
									end
								end
							end else if (mode inside {MODE_REPLACE, MODE_ALT, MODE_OR}) begin
								if (pos_q < lim) begin
									if (cmd_q.pause) begin
										played = rdata_q[KEY_W-1:0] & cfg.key_filter;
									end else if (timer_q != '0) begin
										timer_d = timer_q - 6'd1;
										played = rdata_q[KEY_W-1:0] & cfg.key_filter;
									end else begin
										pos_d = pos1;
										if (pos1 < lim) begin
											played = rdata_q[KEY_W-1:0] & cfg.key_filter;
											timer_d = rdata_q[WORD_W-1:KEY_W];
										end
									end
								end
								if (mode == MODE_REPLACE) begin
									keys = played;
								end else if (mode == MODE_OR) begin
									keys = keys | played;
								end else begin
									ev_a = trk_events(alt_q, played);
									alt_d = trk_next(alt_q, played);
								end
							end
							ev_m = trk_events(main_q, keys);
							main_d = trk_next(main_q, keys);
						end
						ACT_START: begin
							keys = cmd_q.raw_keys;
							pos_d = '0;
							timer_d = '0;
							alt_d = '0;
							case (mode)
								MODE_REC: state_d = ST_WIPE;
								MODE_REPLACE: begin
									keys = rdata_q[KEY_W-1:0];
									timer_d = rdata_q[WORD_W-1:KEY_W];
								end
								MODE_ALT: begin
									timer_d = rdata_q[WORD_W-1:KEY_W];
									alt_d.prev = rdata_q[KEY_W-1:0] & cfg.key_filter;
									alt_d.rref = rdata_q[KEY_W-1:0] & cfg.key_filter;
								end
								MODE_OR: begin
									keys = keys | rdata_q[KEY_W-1:0];
									timer_d = rdata_q[WORD_W-1:KEY_W];
								end
								default: ;
							endcase
							main_d.prev = keys & cfg.key_filter;
							main_d.rref = keys & cfg.key_filter;
							main_d.count = '0;
						end
						ACT_LOAD: begin
							mem_we = idx_ok;
							waddr = idxq_x[AW-1:0];
							wdata = cmd_q.entry_word;
						end
						ACT_READ: rd = idx_ok ? rdata_q : '0;
						default: ;
					endcase
					ev_m.held = main_d.prev;
					ev_a.held = alt_d.prev;
					res_d.main = ev_m;
					res_d.alt = ev_a;
					res_d.next_position = (pos_d < lim) ? pos_d + 11'd1 : pos_d;
					res_d.reached_end = (pos_d >= lim);
					res_d.read_word = rd;
				end
			end
			ST_WIPE: begin
				// clear entries below the limit; entry 0 takes the start keys
				mem_we = 1'b1;
				waddr = sweep_q;
				wdata = (sweep_q == '0) ? {6'b0, main_q.prev} : '0;
				if ((sweep_x + 17'd1) >= {6'b0, lim}) begin
					sweep_d = '0;
					state_d = ST_IDLE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res = res_q;
	assign res_valid = res_valid_q;
	assign stat.clearing = (state_q == ST_CLEAR);

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !pop) else $error("word taken during store clear");
	a_pop_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_EXEC)) else $error("popped word not executed");
	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re)) else $error("store read and write in one cycle");

endmodule
`default_nettype wire
